/* src/mlrqs_pkg.sv */
// shared types and codes for the multilevel ready-queue scheduler
`default_nettype none

package mlrqs_pkg;

  // input action codes
  typedef enum logic [1:0] {
    ACT_ENQUEUE  = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_CHG_PRIO = 2'd2,
    ACT_LEAVE    = 2'd3
  } act_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_PREEMPT    = 3'd1,
    ST_DISPATCHED = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MULTILEVEL = 2'd0,
    CFG_LEVELS     = 2'd1,
    CFG_PREEMPT    = 2'd2,
    CFG_RR_LEVELS  = 2'd3
  } cfg_idx_t;

  // which values go onto the result fields
  typedef enum logic [2:0] {
    SEL_REQ_DST,   // request id and priority, destination level
    SEL_REQ_CUR,   // request id and priority, level where the entry was found
    SEL_REQ_ZERO,  // request id and priority, level zero
    SEL_VICTIM,    // running id and priority, destination level
    SEL_DISPATCH,  // head entry just read, its level and quantum flag
    SEL_ZERO       // all fields zero
  } rsp_sel_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_DSP,
    S_DSP_WAIT,
    S_SRCH,
    S_SRCH_CMP,
    S_SHIFT,
    S_SHIFT_WR,
    S_PUSH,
    S_LEAVE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;      // latch the request, restart the scan
    logic     push;      // append request at tail of destination level
    logic     rd_head;   // read head of most urgent non-empty level
    logic     pop;       // retire that head, make it the running process
    logic     rd_scan;   // read entry at scan position
    logic     next_lvl;  // scan moves to next level
    logic     next_pos;  // scan moves to next position
    logic     set_prio;  // rewrite found entry with new priority
    logic     shift_rd;  // read entry behind the scan position
    logic     shift_wr;  // write that entry one place forward
    logic     dec_cnt;   // found level loses one entry
    logic     leave;     // running process left the cpu
    logic     rsp;       // register a result
    status_t  rsp_code;
    rsp_sel_t rsp_sel;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic any_ready;   // some level in use holds an entry
    logic enq_full;    // destination level is full
    logic preempt;     // arrival is more urgent than the running process
    logic scan_done;   // scan went past the last level in use
    logic lvl_done;    // scan position past the end of current level
    logic match;       // entry read matches the requested id
    logic move_full;   // move target is another, full level
    logic multi;       // per-level mode
    logic shift_more;  // an entry stands behind the scan position
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/mlrqs_ctrl.sv */
// controller state machine of the ready-queue scheduler
`default_nettype none

module mlrqs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [1:0]         action,
  input  wire mlrqs_pkg::dp_stat_t stat,
  output mlrqs_pkg::dp_cmd_t      cmd,
  output logic                    busy
);
  import mlrqs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_ENQUEUE:  state_nxt = S_ENQ;
            ACT_DISPATCH: state_nxt = S_DSP;
            ACT_CHG_PRIO: state_nxt = S_SRCH;
            default:      state_nxt = S_LEAVE;
          endcase
        end
      end
      S_ENQ: state_nxt = S_IDLE;
      S_DSP: begin
        if (stat.any_ready) state_nxt = S_DSP_WAIT;
        else                state_nxt = S_IDLE;
      end
      S_DSP_WAIT: state_nxt = S_IDLE;
      S_SRCH: begin
        if (stat.scan_done)     state_nxt = S_IDLE;
        else if (!stat.lvl_done) state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (!stat.match)          state_nxt = S_SRCH;
        else if (!stat.multi)     state_nxt = S_IDLE;
        else if (stat.move_full)  state_nxt = S_IDLE;
        else                      state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.shift_more) state_nxt = S_SHIFT_WR;
        else                 state_nxt = S_PUSH;
      end
      S_SHIFT_WR: state_nxt = S_SHIFT;
      S_PUSH:     state_nxt = S_IDLE;
      S_LEAVE:    state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.rsp_code = ST_ACCEPTED;
    cmd.rsp_sel  = SEL_ZERO;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_ENQ: begin
        cmd.rsp = 1'b1;
        if (stat.enq_full) begin
          cmd.rsp_code = ST_FULL;
          cmd.rsp_sel  = SEL_REQ_DST;
        end else if (stat.preempt) begin
          cmd.push     = 1'b1;
          cmd.rsp_code = ST_PREEMPT;
          cmd.rsp_sel  = SEL_VICTIM;
        end else begin
          cmd.push     = 1'b1;
          cmd.rsp_code = ST_ACCEPTED;
          cmd.rsp_sel  = SEL_REQ_DST;
        end
      end
      S_DSP: begin
        if (stat.any_ready) begin
          cmd.rd_head = 1'b1;
        end else begin
          cmd.rsp      = 1'b1;
          cmd.rsp_code = ST_EMPTY;
          cmd.rsp_sel  = SEL_ZERO;
        end
      end
      S_DSP_WAIT: begin
        cmd.pop      = 1'b1;
        cmd.rsp      = 1'b1;
        cmd.rsp_code = ST_DISPATCHED;
        cmd.rsp_sel  = SEL_DISPATCH;
      end
      S_SRCH: begin
        if (stat.scan_done) begin
          cmd.rsp      = 1'b1;
          cmd.rsp_code = ST_NOT_FOUND;
          cmd.rsp_sel  = SEL_REQ_ZERO;
        end else if (stat.lvl_done) begin
          cmd.next_lvl = 1'b1;
        end else begin
          cmd.rd_scan = 1'b1;
        end
      end
      S_SRCH_CMP: begin
        if (!stat.match) begin
          cmd.next_pos = 1'b1;
        end else if (!stat.multi) begin
          cmd.set_prio = 1'b1;
          cmd.rsp      = 1'b1;
          cmd.rsp_code = ST_ACCEPTED;
          cmd.rsp_sel  = SEL_REQ_CUR;
        end else if (stat.move_full) begin
          cmd.rsp      = 1'b1;
          cmd.rsp_code = ST_FULL;
          cmd.rsp_sel  = SEL_REQ_DST;
        end
      end
      S_SHIFT: begin
        if (stat.shift_more) cmd.shift_rd = 1'b1;
        else                 cmd.dec_cnt  = 1'b1;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
      end
      S_PUSH: begin
        cmd.push     = 1'b1;
        cmd.rsp      = 1'b1;
        cmd.rsp_code = ST_ACCEPTED;
        cmd.rsp_sel  = SEL_REQ_DST;
      end
      S_LEAVE: begin
        cmd.leave    = 1'b1;
        cmd.rsp      = 1'b1;
        cmd.rsp_code = ST_ACCEPTED;
        cmd.rsp_sel  = SEL_ZERO;
      end
      default: begin
        cmd.rsp_sel = SEL_ZERO;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

/* src/mlrqs_dp.sv */
// datapath of the ready-queue scheduler: slot memory, level pointers, running process
`default_nettype none

module mlrqs_dp #(
  parameter int LEVELS          = 8,
  parameter int SLOTS_PER_LEVEL = 8,
  parameter int PID_BITS        = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic [15:0]        in_proc_id,
  input  wire logic [7:0]         in_priority_req,
  input  wire mlrqs_pkg::dp_cmd_t cmd,
  output mlrqs_pkg::dp_stat_t     stat,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [15:0]             out_pid,
  output logic [7:0]              out_priority,
  output logic [2:0]              out_level,
  output logic                    out_start_quantum
);
  import mlrqs_pkg::*;

  localparam int PW    = (PID_BITS < 16) ? PID_BITS : 16;
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int NW    = $clog2(LEVELS + 1);
  localparam int HW    = $clog2(SLOTS_PER_LEVEL);
  localparam int CW    = $clog2(SLOTS_PER_LEVEL + 1);
  localparam int SW    = CW + 1;
  localparam int TOTAL = LEVELS * SLOTS_PER_LEVEL;
  localparam int AW    = $clog2(TOTAL);
  localparam int RRW   = 1 << LW;
  localparam int EW    = PW + 8;

  // configuration registers
  logic          cfg_multi_r;
  logic [3:0]    cfg_levels_r;
  logic          cfg_preempt_r;
  logic [7:0]    cfg_rr_r;

  // latched request and scan position
  logic [PW-1:0] pid_r;
  logic [7:0]    prio_r;
  logic [NW-1:0] cur_r;
  logic [CW-1:0] pos_r;

  // per-level ring pointers
  logic [HW-1:0] head_r [LEVELS];
  logic [CW-1:0] cnt_r  [LEVELS];

  // running process
  logic          run_valid_r;
  logic [PW-1:0] run_pid_r;
  logic [7:0]    run_prio_r;

  // slot memory
  logic [EW-1:0] mem [TOTAL];
  logic [EW-1:0] rd_data_r;

  // result registers
  logic          out_valid_r;
  status_t       out_status_r;
  logic [15:0]   out_pid_r;
  logic [7:0]    out_priority_r;
  logic [2:0]    out_level_r;
  logic          out_quantum_r;

  logic [NW-1:0] n_act;
  logic [4:0]    lu5;
  logic [LW-1:0] dst;
  logic [LW-1:0] cur_idx;
  logic [LW-1:0] dsp_lvl;
  logic          any_ready;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [RRW-1:0] rr_ext;

  // slot address of position pos in a level ring
  function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lvl,
                                              input logic [HW-1:0] head,
                                              input logic [CW-1:0] pos);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(pos);
    if (s >= SW'(SLOTS_PER_LEVEL)) s = s - SW'(SLOTS_PER_LEVEL);
    return (AW'(lvl) * AW'(SLOTS_PER_LEVEL)) + AW'(s);
  endfunction

  // head advance with wrap
  function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
    return (h == HW'(SLOTS_PER_LEVEL - 1)) ? '0 : h + HW'(1);
  endfunction

  assign cur_idx = cur_r[LW-1:0];
  assign lu5     = 5'(cfg_levels_r);
  assign rr_ext  = RRW'(cfg_rr_r);

  // levels in use
  always_comb begin
    if (!cfg_multi_r)               n_act = NW'(1);
    else if (lu5 == 5'd0)           n_act = NW'(1);
    else if (lu5 > 5'(LEVELS))      n_act = NW'(LEVELS);
    else                            n_act = NW'(lu5);
  end

  // destination level: priority clamped to last level in use
  always_comb begin
    if (prio_r >= 8'(n_act)) dst = LW'(n_act - NW'(1));
    else                     dst = LW'(prio_r);
  end

  // most urgent non-empty level in use
  always_comb begin
    any_ready = 1'b0;
    dsp_lvl   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if ((NW'(l) < n_act) && (cnt_r[l] != '0)) begin
        any_ready = 1'b1;
        dsp_lvl   = LW'(l);
      end
    end
  end

  // status toward the controller
  always_comb begin
    stat.any_ready  = any_ready;
    stat.enq_full   = (cnt_r[dst] == CW'(SLOTS_PER_LEVEL));
    stat.preempt    = cfg_multi_r && cfg_preempt_r && run_valid_r &&
                      (8'(dst) < run_prio_r);
    stat.scan_done  = (cur_r >= n_act);
    stat.lvl_done   = (pos_r >= cnt_r[cur_idx]);
    stat.match      = (rd_data_r[PW-1:0] == pid_r);
    stat.move_full  = (NW'(dst) != cur_r) && (cnt_r[dst] == CW'(SLOTS_PER_LEVEL));
    stat.multi      = cfg_multi_r;
    stat.shift_more = ((pos_r + CW'(1)) < cnt_r[cur_idx]);
  end

  // memory read port address
  always_comb begin
    rd_en = cmd.rd_head | cmd.rd_scan | cmd.shift_rd;
    if (cmd.rd_head)       rd_addr = slot_addr(dsp_lvl, head_r[dsp_lvl], '0);
    else if (cmd.shift_rd) rd_addr = slot_addr(cur_idx, head_r[cur_idx], pos_r + CW'(1));
    else                   rd_addr = slot_addr(cur_idx, head_r[cur_idx], pos_r);
  end

  // memory write port address and data
  always_comb begin
    wr_en = cmd.push | cmd.set_prio | cmd.shift_wr;
    if (cmd.push) begin
      wr_addr = slot_addr(dst, head_r[dst], cnt_r[dst]);
      wr_data = {prio_r, pid_r};
    end else if (cmd.set_prio) begin
      wr_addr = slot_addr(cur_idx, head_r[cur_idx], pos_r);
      wr_data = {prio_r, pid_r};
    end else begin
      wr_addr = slot_addr(cur_idx, head_r[cur_idx], pos_r);
      wr_data = rd_data_r;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_multi_r   <= 1'b1;
      cfg_levels_r  <= 4'd8;
      cfg_preempt_r <= 1'b0;
      cfg_rr_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MULTILEVEL: cfg_multi_r   <= cfg_wdata[0];
        CFG_LEVELS:     cfg_levels_r  <= cfg_wdata[3:0];
        CFG_PREEMPT:    cfg_preempt_r <= cfg_wdata[0];
        CFG_RR_LEVELS:  cfg_rr_r      <= cfg_wdata;
        default:        cfg_rr_r      <= cfg_rr_r;
      endcase
    end
  end

  // request latch and scan position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pid_r  <= in_proc_id[PW-1:0];
      prio_r <= in_priority_req;
      cur_r  <= '0;
      pos_r  <= '0;
    end else if (cmd.rd_head) begin
      cur_r  <= NW'(dsp_lvl);
    end else if (cmd.next_lvl) begin
      cur_r  <= cur_r + NW'(1);
      pos_r  <= '0;
    end else if (cmd.next_pos || cmd.shift_wr) begin
      pos_r  <= pos_r + CW'(1);
    end
  end

  // level heads and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      if (cmd.push) cnt_r[dst] <= cnt_r[dst] + CW'(1);
      if (cmd.pop) begin
        head_r[cur_idx] <= head_inc(head_r[cur_idx]);
        cnt_r[cur_idx]  <= cnt_r[cur_idx] - CW'(1);
      end
      if (cmd.dec_cnt) cnt_r[cur_idx] <= cnt_r[cur_idx] - CW'(1);
    end
  end

  // running process
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      run_pid_r   <= '0;
      run_prio_r  <= '0;
    end else if (cmd.pop) begin
      run_valid_r <= 1'b1;
      run_pid_r   <= rd_data_r[PW-1:0];
      run_prio_r  <= rd_data_r[EW-1:PW];
    end else if (cmd.leave) begin
      run_valid_r <= 1'b0;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.rsp;
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.rsp) begin
      out_status_r <= cmd.rsp_code;
      case (cmd.rsp_sel)
        SEL_REQ_DST: begin
          out_pid_r      <= 16'(pid_r);
          out_priority_r <= prio_r;
          out_level_r    <= 3'(dst);
          out_quantum_r  <= 1'b0;
        end
        SEL_REQ_CUR: begin
          out_pid_r      <= 16'(pid_r);
          out_priority_r <= prio_r;
          out_level_r    <= 3'(cur_idx);
          out_quantum_r  <= 1'b0;
        end
        SEL_REQ_ZERO: begin
          out_pid_r      <= 16'(pid_r);
          out_priority_r <= prio_r;
          out_level_r    <= '0;
          out_quantum_r  <= 1'b0;
        end
        SEL_VICTIM: begin
          out_pid_r      <= 16'(run_pid_r);
          out_priority_r <= run_prio_r;
          out_level_r    <= 3'(dst);
          out_quantum_r  <= 1'b0;
        end
        SEL_DISPATCH: begin
          out_pid_r      <= 16'(rd_data_r[PW-1:0]);
          out_priority_r <= rd_data_r[EW-1:PW];
          out_level_r    <= 3'(cur_idx);
          out_quantum_r  <= rr_ext[cur_idx];
        end
        default: begin
          out_pid_r      <= '0;
          out_priority_r <= '0;
          out_level_r    <= '0;
          out_quantum_r  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_pid           = out_pid_r;
  assign out_priority      = out_priority_r;
  assign out_level         = out_level_r;
  assign out_start_quantum = out_quantum_r;

endmodule

`default_nettype wire

/* src/multilevel_ready_queue_scheduler_unit.sv */
// top level of the multilevel ready-queue scheduler
//
//  channel   ports                                           handshake
//  --------  ----------------------------------------------  ----------------------------
//  request   in_action, in_proc_id, in_priority_req          start high while busy low
//  result    out_status, out_pid, out_priority, out_level,    out_valid for one cycle
//            out_start_quantum
//  config    cfg_index, cfg_wdata                            cfg_we high, no wait
//
// one request at a time; busy stays high until its result strobe has been registered.
// change priority scans the levels in use slot by slot; it ends when the id is not found,
// when only the priority changes or the target level is full, else it moves the entries
// behind the found one forward and appends the request at the tail of the target level.
// the controller uses the slot memory for one read or one write per cycle.
// reset is synchronous and empties all levels; slot contents need no clearing pass.
// the receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module multilevel_ready_queue_scheduler_unit #(
  parameter int LEVELS          = 8,
  parameter int SLOTS_PER_LEVEL = 8,
  parameter int PID_BITS        = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_proc_id,
  input  wire logic [7:0]  in_priority_req,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [15:0]      out_pid,
  output logic [7:0]       out_priority,
  output logic [2:0]       out_level,
  output logic             out_start_quantum
);
  import mlrqs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  mlrqs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // queues and result registers
  mlrqs_dp #(
    .LEVELS          (LEVELS),
    .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL),
    .PID_BITS        (PID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_proc_id        (in_proc_id),
    .in_priority_req   (in_priority_req),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_pid           (out_pid),
    .out_priority      (out_priority),
    .out_level         (out_level),
    .out_start_quantum (out_start_quantum)
  );

endmodule

`default_nettype wire
